// ===== rtl/lagrange_cubic_image_resampler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cubic Lagrange image resampler
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef LAGRANGE_CUBIC_IMAGE_RESAMPLER_ASSERT_SVH
`define LAGRANGE_CUBIC_IMAGE_RESAMPLER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define LCIR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define LCIR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcir_pkg.sv =====
// ----------------------------------------------------------------------------
// lcir_pkg
// Shared constants, codes and the pass finishing function of the resampler.
// ----------------------------------------------------------------------------
package lcir_pkg;

  // default sizes
  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned FracBitsDef  = 16;

  // field widths
  localparam int unsigned CoordW   = 12;
  localparam int unsigned ColourW  = 8;
  localparam int unsigned PixW     = 3 * ColourW;
  localparam int unsigned SizeRegW = 9;
  localparam int unsigned ScaleW   = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned PosW     = CoordW + ScaleW;

  // weight arithmetic
  localparam int unsigned WeightBits = 12;
  localparam int unsigned TW         = WeightBits + 2;          // window position t
  localparam int unsigned MulBW      = WeightBits + 4;          // narrow operand
  localparam int unsigned WgtW       = 3 * (WeightBits + 2) + 3; // scaled numerator
  localparam int unsigned MulAW      = WgtW;                    // wide operand
  localparam int unsigned ProdW      = MulAW + MulBW;
  localparam int unsigned AccW       = WgtW + ColourW + 4;
  localparam int unsigned SumShift   = 3 * WeightBits;

  // divide by six: reciprocal multiply, exact below the saturation limit
  localparam int unsigned Recip6     = 43691;
  localparam int unsigned RecipShift = 18;
  localparam int unsigned SatLimit   = 6 * 256;
  localparam int unsigned QW         = 11;

  // command codes
  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdRender = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSrcWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSrcHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInvScale  = 2'd2;

  // Turn a pass sum into a byte: non-positive gives 0, else sum/(6*2^36)
  // truncated and saturated at 255.
  function automatic logic [ColourW-1:0] lcir_finish(input logic signed [AccW-1:0] acc);
    logic [AccW-1:0]        s;
    logic [QW+16-1:0]       m;
    logic [ColourW-1:0]     q;
    s = AccW'(acc >>> SumShift);
    m = '0;
    if (acc[AccW-1] || acc == '0) begin
      q = '0;
    end else if (s >= AccW'(SatLimit)) begin
      q = '1;
    end else begin
      m = (QW+16)'(s[QW-1:0]) * (QW+16)'(Recip6);
      q = m[RecipShift +: ColourW];
    end
    return q;
  endfunction

endpackage

// ===== rtl/lcir_ram.sv =====
// ----------------------------------------------------------------------------
// lcir_ram
// Generic single-port RAM, one write or read a cycle, registered read data.
// ----------------------------------------------------------------------------
module lcir_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // storage and read register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lagrange_cubic_image_resampler.sv =====
// ----------------------------------------------------------------------------
// lagrange_cubic_image_resampler
// RGB image store with cubic Lagrange resampling of one output pixel per
// render command, the position, weight and interpolation products on one shared multiplier.
// ----------------------------------------------------------------------------
// Channel   | Handshake               | Payload
// command   | start / busy            | command_i column_i row_i *_in_i
// result    | strobe_o (one cycle)    | red/green/blue_out_o computed_o
// config    | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// A load is accepted without going busy: the pixel is written at the accepting edge.
// A render stays busy through the position products and set-up, then, when
// inside the margin, 16 window reads (one read, three colour multiplies each),
// the weight products, 12 column multiplies and the bookkeeping in between;
// the single multiplier and the single RAM port set this sequence.
// The image store has no reset; config registers reset to 256, 256, 1.0.
// strobe_o marks each result for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "lagrange_cubic_image_resampler_assert.svh"

module lagrange_cubic_image_resampler
  import lcir_pkg::*;
#(
  parameter int unsigned MaxWidth  = MaxWidthDef,
  parameter int unsigned MaxHeight = MaxHeightDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic                command_i,
  input  logic [CoordW-1:0]   column_i,
  input  logic [CoordW-1:0]   row_i,
  input  logic [ColourW-1:0]  red_in_i,
  input  logic [ColourW-1:0]  green_in_i,
  input  logic [ColourW-1:0]  blue_in_i,
  // result channel
  output logic                strobe_o,
  output logic [ColourW-1:0]  red_out_o,
  output logic [ColourW-1:0]  green_out_o,
  output logic [ColourW-1:0]  blue_out_o,
  output logic                computed_o,
  // config channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned XW     = $clog2(MaxWidth);
  localparam int unsigned YW     = $clog2(MaxHeight);
  localparam int unsigned Depth  = MaxWidth * MaxHeight;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned MaxDim = (MaxWidth > MaxHeight) ? MaxWidth : MaxHeight;
  localparam int unsigned SzW    = $clog2(MaxDim) + 1;
  localparam int unsigned ShR    = (FracBits >= WeightBits) ? FracBits - WeightBits : 0;
  localparam int unsigned ShL    = (FracBits >= WeightBits) ? 0 : WeightBits - FracBits;

  localparam logic signed [MulBW-1:0] OneW = MulBW'(2 ** WeightBits);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_POS    = 11'b00000000010,
    S_SETUP  = 11'b00000000100,
    S_WGT    = 11'b00000001000,
    S_FETCH  = 11'b00000010000,
    S_MAC    = 11'b00000100000,
    S_DRAIN  = 11'b00001000000,
    S_ROWEND = 11'b00010000000,
    S_COL    = 11'b00100000000,
    S_FIN    = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  typedef struct packed {
    logic            ok;
    logic [PosW-1:0] start;
    logic [TW-1:0]   t;
  } axis_t;

  // margin test, window start and window position for one axis
  function automatic axis_t axis_calc(input logic [PosW-1:0] p, input logic [SzW-1:0] size);
    axis_t           a;
    logic            lower;
    logic [PosW-1:0] whole;
    logic [PosW-1:0] frac;
    logic [PosW-1:0] u;
    whole   = p >> FracBits;
    frac    = p & ((PosW'(1) << FracBits) - PosW'(1));
    u       = (frac >> ShR) << ShL;
    lower   = p < (PosW'(size >> 1) << FracBits);
    a.ok    = (p >= (PosW'(1) << FracBits)) && (p <= (PosW'(size - SzW'(2)) << FracBits));
    a.start = lower ? whole - PosW'(1) : whole - PosW'(2);
    a.t     = TW'(u[WeightBits-1:0]) +
              (lower ? (TW'(1) << WeightBits) : (TW'(2) << WeightBits));
    return a;
  endfunction

  // control state
  state_e       state_q, state_d;
  logic [3:0]   step_q, step_d;
  logic         axis_q, axis_d;
  logic [1:0]   r_q, r_d;
  logic [1:0]   k_q, k_d;
  logic [1:0]   ch_q, ch_d;
  logic         colph_q, colph_d;
  logic         pend_q, pend_d;
  logic [1:0]   pend_ch_q, pend_ch_d;

  // config registers
  logic [SizeRegW-1:0] src_w_q, src_h_q;
  logic [ScaleW-1:0]   inv_q;

  // datapath registers
  logic [CoordW-1:0]        col_q, row_q;
  logic [PosW-1:0]          px_q, py_q;
  logic [XW-1:0]            x0_q;
  logic [YW-1:0]            y0_q;
  logic [TW-1:0]            tx_q, ty_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [WgtW-1:0]   wx_q [4];
  logic signed [WgtW-1:0]   wy_q [4];
  logic signed [AccW-1:0]   acc_q [3];
  logic [ColourW-1:0]       rowv_q [3][4];
  logic [ColourW-1:0]       res_q [3];
  logic                     computed_q;

  // combinational
  logic [SzW-1:0]           eff_w, eff_h;
  axis_t                    ax, ay;
  logic [TW-1:0]            tsel;
  logic signed [MulBW-1:0]  a0, a1, a2, a3;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  mul_p;
  logic signed [WgtW-1:0]   pw, pw3, wval;
  logic [1:0]               wk;
  logic [ColourW-1:0]       dbyte;
  logic                     accept, ram_we, ram_re;
  logic [AddrW-1:0]         wr_addr, rd_addr, ram_addr;
  logic [PixW-1:0]          ram_rdata;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SizeRegW'(256);
      src_h_q <= SizeRegW'(256);
      inv_q   <= ScaleW'(65536);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegSrcWidth:  src_w_q <= cfg_data_i[SizeRegW-1:0];
        RegSrcHeight: src_h_q <= cfg_data_i[SizeRegW-1:0];
        RegInvScale:  inv_q   <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // effective image size, saturated to 4..max
  always_comb begin
    if (src_w_q < SizeRegW'(4))       eff_w = SzW'(4);
    else if (32'(src_w_q) > MaxWidth) eff_w = SzW'(MaxWidth);
    else                              eff_w = SzW'(src_w_q);
    if (src_h_q < SizeRegW'(4))        eff_h = SzW'(4);
    else if (32'(src_h_q) > MaxHeight) eff_h = SzW'(MaxHeight);
    else                               eff_h = SzW'(src_h_q);
  end

  assign ax = axis_calc(px_q, eff_w);
  assign ay = axis_calc(py_q, eff_h);

  // Lagrange factors t - k for the axis in work
  assign tsel = axis_q ? ty_q : tx_q;
  assign a0   = $signed(MulBW'(tsel));
  assign a1   = a0 - OneW;
  assign a2   = a1 - OneW;
  assign a3   = a2 - OneW;

  // colour byte of the fetched pixel
  always_comb begin
    case (ch_q)
      2'd0:    dbyte = ram_rdata[2*ColourW +: ColourW];
      2'd1:    dbyte = ram_rdata[ColourW +: ColourW];
      default: dbyte = ram_rdata[0 +: ColourW];
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_POS: begin
        mul_a = MulAW'($signed({1'b0, inv_q}));
        mul_b = (step_q == 4'd0) ? MulBW'($signed({1'b0, col_q}))
                                 : MulBW'($signed({1'b0, row_q}));
      end
      S_WGT: begin
        case (step_q)
          4'd0: begin mul_a = MulAW'(a1); mul_b = a2; end
          4'd1: begin mul_a = prod_q[MulAW-1:0]; mul_b = a3; end
          4'd2: begin mul_a = MulAW'(a2); mul_b = a3; end
          4'd3: begin mul_a = prod_q[MulAW-1:0]; mul_b = a0; end
          4'd4: begin mul_a = MulAW'(a1); mul_b = a3; end
          4'd5: begin mul_a = prod_q[MulAW-1:0]; mul_b = a0; end
          4'd6: begin mul_a = MulAW'(a0); mul_b = a1; end
          4'd7: begin mul_a = prod_q[MulAW-1:0]; mul_b = a2; end
          default: ;
        endcase
      end
      S_MAC: begin
        mul_a = MulAW'(wx_q[k_q]);
        mul_b = $signed(MulBW'(dbyte));
      end
      S_COL: begin
        mul_a = MulAW'(wy_q[r_q]);
        mul_b = $signed(MulBW'(rowv_q[ch_q][r_q]));
      end
      default: ;
    endcase
  end

  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  // weight write-back: steps 2, 4, 6, 8 close N0..N3
  assign pw  = prod_q[WgtW-1:0];
  assign pw3 = (pw <<< 1) + pw;
  assign wk  = 2'((step_q >> 1) - 4'd1);
  always_comb begin
    case (step_q)
      4'd2:    wval = -pw;
      4'd4:    wval = pw3;
      4'd6:    wval = -pw3;
      default: wval = pw;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    axis_d    = axis_q;
    r_d       = r_q;
    k_d       = k_q;
    ch_d      = ch_q;
    colph_d   = colph_q;
    pend_d    = 1'b0;
    pend_ch_d = ch_q;
    unique case (state_q)
      S_IDLE: begin
        if (start && command_i == CmdRender) begin
          state_d = S_POS;
          step_d  = '0;
        end
      end
      S_POS: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd2) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        step_d = '0;
        axis_d = 1'b0;
        state_d = (ax.ok && ay.ok) ? S_WGT : S_OUT;
      end
      S_WGT: begin
        if (step_q == 4'd8) begin
          step_d = '0;
          if (axis_q) begin
            state_d = S_FETCH;
            r_d     = '0;
            k_d     = '0;
            ch_d    = '0;
            colph_d = 1'b0;
          end else begin
            axis_d = 1'b1;
          end
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      S_FETCH: begin
        state_d = S_MAC;
        ch_d    = '0;
      end
      S_MAC: begin
        pend_d = 1'b1;
        if (ch_q == 2'd2) begin
          ch_d = '0;
          k_d  = k_q + 2'd1;
          state_d = (k_q == 2'd3) ? S_DRAIN : S_FETCH;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      S_DRAIN: begin
        state_d = colph_q ? S_FIN : S_ROWEND;
      end
      S_ROWEND: begin
        r_d = r_q + 2'd1;
        if (r_q == 2'd3) begin
          ch_d    = '0;
          colph_d = 1'b1;
          state_d = S_COL;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_COL: begin
        pend_d = 1'b1;
        if (ch_q == 2'd2) begin
          ch_d = '0;
          r_d  = r_q + 2'd1;
          if (r_q == 2'd3) begin
            state_d = S_DRAIN;
          end
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      S_FIN:   state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      axis_q    <= 1'b0;
      r_q       <= '0;
      k_q       <= '0;
      ch_q      <= '0;
      colph_q   <= 1'b0;
      pend_q    <= 1'b0;
      pend_ch_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      axis_q    <= axis_d;
      r_q       <= r_d;
      k_q       <= k_d;
      ch_q      <= ch_d;
      colph_q   <= colph_d;
      pend_q    <= pend_d;
      pend_ch_q <= pend_ch_d;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (accept) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    // source positions
    if (state_q == S_POS && step_q == 4'd1) px_q <= prod_q[PosW-1:0];
    if (state_q == S_POS && step_q == 4'd2) py_q <= prod_q[PosW-1:0];
    // window set-up, or an empty result when outside the margin
    if (state_q == S_SETUP) begin
      x0_q <= ax.start[XW-1:0];
      y0_q <= ay.start[YW-1:0];
      tx_q <= ax.t;
      ty_q <= ay.t;
      for (int c = 0; c < 3; c++) acc_q[c] <= '0;
      if (!(ax.ok && ay.ok)) begin
        for (int c = 0; c < 3; c++) res_q[c] <= '0;
        computed_q <= 1'b0;
      end
    end
    // weights
    if (state_q == S_WGT && (step_q == 4'd2 || step_q == 4'd4 ||
                             step_q == 4'd6 || step_q == 4'd8)) begin
      if (axis_q) wy_q[wk] <= wval;
      else        wx_q[wk] <= wval;
    end
    // accumulate the product issued last cycle
    if (pend_q) begin
      acc_q[pend_ch_q] <= acc_q[pend_ch_q] + AccW'(prod_q);
    end
    // close a row pass
    if (state_q == S_ROWEND) begin
      for (int c = 0; c < 3; c++) begin
        rowv_q[c][r_q] <= lcir_finish(acc_q[c]);
        acc_q[c]       <= '0;
      end
    end
    // close the column pass
    if (state_q == S_FIN) begin
      for (int c = 0; c < 3; c++) res_q[c] <= lcir_finish(acc_q[c]);
      computed_q <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // image store
  assign ram_we  = accept && (command_i == CmdLoad) &&
                   (32'(column_i) < MaxWidth) && (32'(row_i) < MaxHeight);
  assign ram_re  = (state_q == S_FETCH);
  assign wr_addr = AddrW'(32'(row_i) * MaxWidth + 32'(column_i));
  assign rd_addr = AddrW'((32'(y0_q) + 32'(r_q)) * MaxWidth + 32'(x0_q) + 32'(k_q));
  assign ram_addr = ram_re ? rd_addr : wr_addr;

  lcir_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .rdata_o (ram_rdata)
  );

  // result transfer
  assign strobe_o    = (state_q == S_OUT);
  assign red_out_o   = res_q[0];
  assign green_out_o = res_q[1];
  assign blue_out_o  = res_q[2];
  assign computed_o  = computed_q;

  // ---------------------------------------------------------------------------
  // checks
  `LCIR_ASSERT_NXT(a_render_busy, clk_i, rst_ni,
                   accept && command_i == CmdRender, busy, "render did not start")
  `LCIR_ASSERT_NXT(a_load_idle, clk_i, rst_ni,
                   accept && command_i == CmdLoad, !busy && !strobe_o, "load left block busy")
  `LCIR_ASSERT_NXT(a_out_idle, clk_i, rst_ni, strobe_o, !busy, "result not followed by idle")
  `LCIR_ASSERT_IMP(a_skip_zero, clk_i, rst_ni, strobe_o && !computed_o,
                   red_out_o == '0 && green_out_o == '0 && blue_out_o == '0,
                   "skipped pixel carries colour")

endmodule

// ===== tb/tb_lagrange_cubic_image_resampler.sv =====
// ----------------------------------------------------------------------------
// Cubic Lagrange image resampler testbench
// Loads small source images and renders output pixels under several scale and
// size settings. Each render transfer is predicted in the bench and every
// strobed result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_lagrange_cubic_image_resampler;
  import lcir_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam int unsigned StoreW = MaxWidthDef;
  localparam int unsigned WdogLimit = 8000;
  localparam int unsigned Settle = 130;

  typedef struct packed {
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] blue;
    logic               computed;
  } pixel_res_t;

  typedef longint weights_t [4];

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                command_i = CmdLoad;
  logic [CoordW-1:0]   column_i = '0;
  logic [CoordW-1:0]   row_i = '0;
  logic [ColourW-1:0]  red_in_i = '0;
  logic [ColourW-1:0]  green_in_i = '0;
  logic [ColourW-1:0]  blue_in_i = '0;
  logic                strobe_o;
  logic [ColourW-1:0]  red_out_o;
  logic [ColourW-1:0]  green_out_o;
  logic [ColourW-1:0]  blue_out_o;
  logic                computed_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  lagrange_cubic_image_resampler dut (.*);

  // predictor state
  logic [PixW-1:0] pix_store [StoreW*MaxHeightDef];
  bit              pix_written [StoreW*MaxHeightDef];
  int unsigned     width_reg = 256, height_reg = 256;
  int unsigned     inv_scale = 65536;
  pixel_res_t      pending_pixels [$];

  int unsigned errors = 0;
  int unsigned n_loads = 0, n_renders = 0, n_computed = 0, n_cfg = 0;
  int unsigned idle_pct = 0;
  int unsigned wdog = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
    if (v < 4) return 4;
    if (v > hi) return hi;
    return v;
  endfunction

  // one axis: false when outside the margin
  function automatic bit axis_map(input longint p, input int unsigned size,
                                  output int unsigned first, output weights_t w);
    longint one, u, a0, a1, a2, a3;
    bit lower;
    one = 64'd1 << FracBitsDef;
    first = 0;
    w = '{0, 0, 0, 0};
    if (p < one || p > (longint'(size - 2) << FracBitsDef)) return 1'b0;
    lower = p < (longint'(size / 2) << FracBitsDef);
    first = lower ? 32'((p >> FracBitsDef) - 1) : 32'((p >> FracBitsDef) - 2);
    u = (p & (one - 1)) >> (FracBitsDef - WeightBits);
    u += longint'(lower ? 1 : 2) << WeightBits;
    a0 = u;
    a1 = u - (64'd1 << WeightBits);
    a2 = u - (64'd2 << WeightBits);
    a3 = u - (64'd3 << WeightBits);
    w[0] = -(a1 * a2 * a3);
    w[1] = 3 * a0 * a2 * a3;
    w[2] = -3 * a0 * a1 * a3;
    w[3] = a0 * a1 * a2;
    return 1'b1;
  endfunction

  function automatic int unsigned weigh(input int unsigned d [4], input weights_t w);
    longint acc;
    longint q;
    acc = 0;
    for (int k = 0; k < 4; k++) acc += longint'(d[k]) * w[k];
    if (acc <= 0) return 0;
    q = acc / (longint'(6) << (3 * WeightBits));
    return (q > 255) ? 255 : int'(q);
  endfunction

  // expected pixel, and whether every window entry has been loaded
  function automatic pixel_res_t interpolate(input int unsigned col, input int unsigned row,
                                             output bit loaded);
    pixel_res_t  res;
    weights_t    wx, wy;
    int unsigned x0, y0, shift;
    int unsigned d [4];
    int unsigned rowv [4];
    int unsigned chan [3];
    res = '0;
    loaded = 1'b1;
    if (!axis_map(longint'(col) * inv_scale, eff_size(width_reg, MaxWidthDef), x0, wx))
      return res;
    if (!axis_map(longint'(row) * inv_scale, eff_size(height_reg, MaxHeightDef), y0, wy))
      return res;
    for (int c = 0; c < 3; c++) begin
      shift = 16 - 8 * c;
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) begin
          if (!pix_written[(y0 + r) * StoreW + x0 + k]) loaded = 1'b0;
          d[k] = (pix_store[(y0 + r) * StoreW + x0 + k] >> shift) & 8'hFF;
        end
        rowv[r] = weigh(d, wx);
      end
      chan[c] = weigh(rowv, wy);
    end
    res.red = ColourW'(chan[0]);
    res.green = ColourW'(chan[1]);
    res.blue = ColourW'(chan[2]);
    res.computed = 1'b1;
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input logic cmd, input int unsigned col, input int unsigned row,
                           input logic [PixW-1:0] rgb);
    pixel_res_t res;
    bit loaded;
    start <= 1'b1;
    command_i <= cmd;
    column_i <= CoordW'(col);
    row_i <= CoordW'(row);
    {red_in_i, green_in_i, blue_in_i} <= rgb;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (cmd == CmdLoad) begin
      n_loads++;
      if (col < MaxWidthDef && row < MaxHeightDef) begin
        pix_store[row * StoreW + col] = rgb;
        pix_written[row * StoreW + col] = 1'b1;
      end
    end else begin
      n_renders++;
      res = interpolate(col, row, loaded);
      if (res.computed) n_computed++;
      pending_pixels = {pending_pixels, res};
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    drain();
    repeat (Settle) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    n_cfg++;
    case (idx)
      RegSrcWidth:  width_reg = value & 9'h1FF;
      RegSrcHeight: height_reg = value & 9'h1FF;
      RegInvScale:  inv_scale = value & 24'hFFFFFF;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned s);
    write_reg(RegSrcWidth, w);
    write_reg(RegSrcHeight, h);
    write_reg(RegInvScale, s);
  endtask

  task automatic load_block(input int unsigned w, input int unsigned h, input bit checker_fill);
    for (int unsigned y = 0; y < h; y++)
      for (int unsigned x = 0; x < w; x++)
        send_item(CmdLoad, x, y, checker_fill ? (((x + y) % 2) ? 24'hFFFFFF : 24'h000000)
                                               : PixW'($urandom));
  endtask

  // ---------------------------------------------------------------- result check
  always @(posedge clk_i) begin
    pixel_res_t want;
    if (rst_ni && strobe_o) begin
      if (pending_pixels.size() == 0) begin
        $error("result strobe with no render outstanding");
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (computed_o !== want.computed) begin
          $error("computed: expected %0d, got %0d", want.computed, computed_o);
          errors++;
        end
        if (red_out_o !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, red_out_o);
          errors++;
        end
        if (green_out_o !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, green_out_o);
          errors++;
        end
        if (blue_out_o !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, blue_out_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o || (cfg_valid_i && cfg_ready_o)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WdogLimit) begin
      $display("lagrange_cubic_image_resampler verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  // reset settings, ignored loads, skipped corners
  task automatic test_reset_defaults();
    load_block(5, 5, 1'b1);
    send_item(CmdLoad, 4095, 4095, 24'hFFFFFF);
    send_item(CmdLoad, 255, 4095, 24'h123456);
    send_item(CmdLoad, 255, 255, 24'hFFFFFF);
    send_item(CmdRender, 0, 0, 24'hFFFFFF);
    send_item(CmdRender, 4095, 4095, 24'h000000);
    send_item(CmdRender, 1, 1, 24'h000000);
    send_item(CmdRender, 1, 2, 24'h000000);
  endtask

  // smallest image: both window halves, zero scale, sizes beyond the limits
  task automatic test_small_image();
    set_geometry(4, 4, 65536);
    send_item(CmdRender, 1, 1, '0);
    send_item(CmdRender, 2, 2, '0);
    send_item(CmdRender, 2, 1, '0);
    send_item(CmdRender, 3, 1, '0);
    write_reg(RegInvScale, 98304);
    send_item(CmdRender, 1, 1, '0);
    write_reg(RegInvScale, 0);
    send_item(CmdRender, 1, 1, '0);
    write_reg(RegInvScale, 24'hFFFFFF);
    send_item(CmdRender, 0, 0, '0);
    send_item(CmdRender, 1, 0, '0);
    set_geometry(0, 3, 40000);
    send_item(CmdRender, 2, 3, '0);
    write_reg(RegSpare, 24'hFFFFFF);
    set_geometry(511, 300, 1);
    send_item(CmdRender, 4095, 4095, '0);
  endtask

  task automatic test_random_phase(input int unsigned idle, input int unsigned n_items,
                                   input bit hold_mid);
    int unsigned wreg, hreg, sreg, region_w, region_h, col, row, span;
    bit loaded;
    pixel_res_t dummy;
    idle_pct = 0;
    wreg = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(4, 10);
    hreg = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(4, 10);
    sreg = ($urandom_range(7) == 0) ? $urandom_range(1, 24'hFFFFFF)
                                    : $urandom_range(20000, 140000);
    set_geometry(wreg, hreg, sreg);
    region_w = eff_size(wreg, 10);
    region_h = eff_size(hreg, 10);
    idle_pct = idle;
    load_block(region_w, region_h, 1'b0);
    span = 32'((longint'(11) << FracBitsDef) / sreg + 2);
    if (span > 4095) span = 4095;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (hold_mid && i == n_items / 2) drain();
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(9) == 0)
          send_item(CmdLoad, $urandom_range(4095), $urandom_range(4095), PixW'($urandom));
        else
          send_item(CmdLoad, $urandom_range(region_w - 1), $urandom_range(region_h - 1),
                    PixW'($urandom));
      end else begin
        loaded = 1'b0;
        for (int t = 0; t < 8 && !loaded; t++) begin
          col = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(span);
          row = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(span);
          dummy = interpolate(col, row, loaded);
        end
        if (loaded) send_item(CmdRender, col, row, PixW'($urandom));
        else send_item(CmdLoad, $urandom_range(region_w - 1), $urandom_range(region_h - 1),
                       PixW'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    int unsigned idles [8] = '{0, 74, 0, 24, 0, 74, 24, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_small_image();
    for (int p = 0; p < 8; p++) test_random_phase(idles[p], 100, p == 3);
    idle_pct = 0;
    drain();
    repeat (Settle) @(posedge clk_i);
    $display("Ran %0d loads and %0d renders (%0d inside the margin) over %0d register writes,",
             n_loads, n_renders, n_computed, n_cfg);
    $display("covering both window halves, skipped pixels and out-of-range sizes and scales.");
    if (errors == 0) begin
      $display("lagrange_cubic_image_resampler verification clean");
    end else begin
      $display("lagrange_cubic_image_resampler verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lcir_pkg.sv
rtl/lcir_ram.sv
rtl/lagrange_cubic_image_resampler.sv
tb/tb_lagrange_cubic_image_resampler.sv
